### hw/rtl/gcd_pkg.sv
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared constants, latencies and types for the great-circle distance
// datapath.
// ----------------------------------------------------------------------------
package gcd_pkg;

    // pi in Q30, rounded
    localparam logic [31:0] PI_Q30 = 32'd3373259426;
    // one in Q30
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    // reset radius of the sphere in km
    localparam logic [13:0] RADIUS_RESET = 14'd6371;

    // divisors of the Taylor series, in Horner order
    localparam int SIN_TERMS = 5;
    localparam int COS_TERMS = 6;
    localparam int SIN_DIV [SIN_TERMS] = '{110, 72, 42, 20, 6};
    localparam int COS_DIV [COS_TERMS] = '{132, 90, 56, 30, 12, 2};

    // bisection steps of the inverse cosine
    localparam int ACOS_STEPS = 31;

    // pipeline latencies in cycles
    localparam int LAT_DIV    = 2;
    localparam int LAT_HORNER = LAT_DIV + 3;
    localparam int LAT_D2T    = 2 * LAT_DIV + 3;
    localparam int LAT_SC     = 5 + COS_TERMS * LAT_HORNER + 1;
    localparam int LAT_STEP   = LAT_SC + 1;
    localparam int LAT_ARG    = 5;
    localparam int LAT_TOTAL  = 1 + LAT_D2T + LAT_SC + LAT_ARG
                                + ACOS_STEPS * LAT_STEP + 5;

    // quadrant of a binary angle after the eighth-turn offset
    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_1,
        QUAD_2,
        QUAD_3
    } t_quad;

    // Q30 value with sign
    typedef logic signed [31:0] t_q30;

endpackage

### hw/rtl/gcd_if.sv
// ----------------------------------------------------------------------------
// gcd_pt_if / gcd_res_if
// Valid/ready channels for coordinate pairs and for distance results.
// ----------------------------------------------------------------------------
interface gcd_pt_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] lat_first;
    logic signed [24:0] lon_first;
    logic signed [23:0] lat_second;
    logic signed [24:0] lon_second;

    modport source (output valid, lat_first, lon_first, lat_second, lon_second,
                    input ready);
    modport sink (input valid, lat_first, lon_first, lat_second, lon_second,
                  output ready);
endinterface

interface gcd_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] central_angle;
    logic [25:0] distance_m;

    modport source (output valid, central_angle, distance_m, input ready);
    modport sink (input valid, central_angle, distance_m, output ready);
endinterface

### hw/rtl/gcd_delay.sv
// ----------------------------------------------------------------------------
// gcd_delay
// Enabled shift line that keeps side data aligned with a pipelined unit.
// ----------------------------------------------------------------------------
module gcd_delay #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_tap [N];

    // advance every tap while the pipeline moves
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_d;
            for (int k = 1; k < N; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_q = r_tap[N-1];

endmodule

### hw/rtl/gcd_divc.sv
// ----------------------------------------------------------------------------
// gcd_divc
// Floor division by a constant: reciprocal multiply, then one correction.
// ----------------------------------------------------------------------------
module gcd_divc #(
    parameter int W = 31,
    parameter int D = 3
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_n,
    output logic [W-1:0] o_q
);

    localparam logic [63:0]  K_FULL = (64'd1 << W) / D;
    localparam logic [W-1:0] K      = K_FULL[W-1:0];
    localparam logic [W-1:0] DV     = W'(D);

    logic [2*W-1:0] r_prod;
    logic [W-1:0]   r_n;
    logic [W-1:0]   r_q;
    logic [W-1:0]   w_q0;
    logic [W-1:0]   w_rem;

    // estimate is exact or one short
    assign w_q0  = r_prod[2*W-1:W];
    assign w_rem = r_n - W'(w_q0 * DV);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= (2*W)'(i_n) * (2*W)'(K);
            r_n    <= i_n;
            r_q    <= (w_rem >= DV) ? w_q0 + W'(1) : w_q0;
        end
    end

    assign o_q = r_q;

endmodule

### hw/rtl/gcd_d2t.sv
// ----------------------------------------------------------------------------
// gcd_d2t
// Signed fixed-point degrees to a 32-bit binary angle, rounded, halves away from zero.
// ----------------------------------------------------------------------------
module gcd_d2t #(
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [25:0] i_deg,
    output logic [31:0]        o_turn
);

    localparam int SH = 32 - ANGLE_FRAC_BITS;

    logic [25:0] r_m;
    logic        r_neg;
    logic [22:0] w_a;
    logic [25:0] w_m2;
    logic        w_neg2;
    logic [8:0]  w_b;
    logic [32:0] w_y;
    logic [29:0] r_yh;
    logic [16:0] r_a;
    logic        r_negb;
    logic [29:0] w_q2;
    logic [16:0] w_a3;
    logic        w_neg3;
    logic [31:0] w_t;
    logic [31:0] r_turn;

    // take the magnitude
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m   <= i_deg[25] ? 26'(-i_deg) : 26'(i_deg);
            r_neg <= i_deg[25];
        end
    end

    // whole multiples of 360: m = 360 a + b
    gcd_divc #(.W(23), .D(45)) u_div_a (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_n   (r_m[25:3]),
        .o_q   (w_a)
    );

    gcd_delay #(.W(27), .N(gcd_pkg::LAT_DIV)) u_dly_m (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_d   ({r_neg, r_m}),
        .o_q   ({w_neg2, w_m2})
    );

    // remainder scaled to the turn, with the rounding half
    assign w_b = 9'(w_m2 - 26'(26'(w_a) * 26'd360));
    assign w_y = (33'(w_b) << SH) + 33'd180;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_yh   <= w_y[32:3];
            r_a    <= w_a[16:0];
            r_negb <= w_neg2;
        end
    end

    gcd_divc #(.W(30), .D(45)) u_div_b (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_n   (r_yh),
        .o_q   (w_q2)
    );

    gcd_delay #(.W(18), .N(gcd_pkg::LAT_DIV)) u_dly_a (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_d   ({r_negb, r_a}),
        .o_q   ({w_neg3, w_a3})
    );

    // combine, wrap to 32 bits and restore the sign
    assign w_t = 32'((64'(w_a3) << SH) + 64'(w_q2));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_turn <= w_neg3 ? 32'(0) - w_t : w_t;
        end
    end

    assign o_turn = r_turn;

endmodule

### hw/rtl/gcd_horner.sv
// ----------------------------------------------------------------------------
// gcd_horner
// One Horner step of the Taylor series: t' = 1 - round(x2 * t) / DIV.
// ----------------------------------------------------------------------------
module gcd_horner #(
    parameter int DIV = 2
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [30:0] i_t,
    input  logic [29:0] i_x2,
    output logic [30:0] o_t,
    output logic [29:0] o_x2
);

    logic [60:0] r_prod;
    logic [60:0] w_sum;
    logic [30:0] r_p;
    logic [30:0] w_q;
    logic [30:0] r_t;

    // product, then round to Q30
    assign w_sum = r_prod + 61'(2**29);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= 61'(i_x2) * 61'(i_t);
            r_p    <= w_sum[60:30];
        end
    end

    gcd_divc #(.W(31), .D(DIV)) u_div (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_n   (r_p),
        .o_q   (w_q)
    );

    // subtract from one
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t <= gcd_pkg::ONE_Q30 - w_q;
        end
    end

    gcd_delay #(.W(30), .N(gcd_pkg::LAT_HORNER)) u_dly_x2 (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_d   (i_x2),
        .o_q   (o_x2)
    );

    assign o_t = r_t;

endmodule

### hw/rtl/gcd_sincos.sv
// ----------------------------------------------------------------------------
// gcd_sincos
// Sine and cosine in Q30 of a binary angle: quadrant fold, radian scaling,
// Horner chains for both series, quadrant map.
// ----------------------------------------------------------------------------
module gcd_sincos (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [31:0]        i_ang,
    output gcd_pkg::t_q30      o_sin,
    output gcd_pkg::t_q30      o_cos
);

    localparam int H = gcd_pkg::LAT_HORNER;

    logic [31:0] w_b;
    logic [2:0]  r_ctl1, r_ctl2, r_ctl3, r_ctl4, r_ctl5;
    logic [29:0] r_mr;
    logic [61:0] r_prod;
    logic [61:0] w_xsum;
    logic [29:0] r_x3, r_x4, r_x5;
    logic [59:0] r_px;
    logic [59:0] w_x2sum;
    logic [29:0] r_x2;
    logic [30:0] w_st  [gcd_pkg::SIN_TERMS+1];
    logic [29:0] w_sx2 [gcd_pkg::SIN_TERMS+1];
    logic [30:0] w_ct  [gcd_pkg::COS_TERMS+1];
    logic [29:0] w_cx2 [gcd_pkg::COS_TERMS+1];
    logic [29:0] w_xd;
    logic [60:0] r_sprod;
    logic [60:0] w_ssum;
    logic [30:0] r_svm;
    logic [30:0] w_svm;
    logic [2:0]  w_ctl;
    gcd_pkg::t_q30 w_sv, w_cv;
    gcd_pkg::t_q30 r_sin, r_cos;
    gcd_pkg::t_q30 n_sin, n_cos;

    // offset by an eighth turn; split into quadrant and signed remainder
    assign w_b = i_ang + 32'h2000_0000;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl1 <= {~w_b[29], w_b[31:30]};
            r_mr   <= w_b[29] ? {1'b0, w_b[28:0]} : 30'h2000_0000 - {1'b0, w_b[28:0]};
        end
    end

    // scale to radians and square
    assign w_xsum  = r_prod + 62'(2**30);
    assign w_x2sum = r_px + 60'(2**29);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= 62'(r_mr) * 62'(gcd_pkg::PI_Q30);
            r_ctl2 <= r_ctl1;
            r_x3   <= w_xsum[60:31];
            r_ctl3 <= r_ctl2;
            r_px   <= 60'(r_x3) * 60'(r_x3);
            r_x4   <= r_x3;
            r_ctl4 <= r_ctl3;
            r_x2   <= w_x2sum[59:30];
            r_x5   <= r_x4;
            r_ctl5 <= r_ctl4;
        end
    end

    // sine series
    assign w_st[0]  = gcd_pkg::ONE_Q30;
    assign w_sx2[0] = r_x2;

    for (genvar i = 0; i < gcd_pkg::SIN_TERMS; i++) begin : g_sin
        gcd_horner #(.DIV(gcd_pkg::SIN_DIV[i])) u_step (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_t   (w_st[i]),
            .i_x2  (w_sx2[i]),
            .o_t   (w_st[i+1]),
            .o_x2  (w_sx2[i+1])
        );
    end

    // cosine series
    assign w_ct[0]  = gcd_pkg::ONE_Q30;
    assign w_cx2[0] = r_x2;

    for (genvar i = 0; i < gcd_pkg::COS_TERMS; i++) begin : g_cos
        gcd_horner #(.DIV(gcd_pkg::COS_DIV[i])) u_step (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_t   (w_ct[i]),
            .i_x2  (w_cx2[i]),
            .o_t   (w_ct[i+1]),
            .o_x2  (w_cx2[i+1])
        );
    end

    // multiply the sine series by x
    gcd_delay #(.W(30), .N(gcd_pkg::SIN_TERMS * H)) u_dly_x (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_d   (r_x5),
        .o_q   (w_xd)
    );

    assign w_ssum = r_sprod + 61'(2**29);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sprod <= 61'(w_xd) * 61'(w_st[gcd_pkg::SIN_TERMS]);
            r_svm   <= w_ssum[60:30];
        end
    end

    // align the sine with the longer cosine chain
    gcd_delay #(.W(31), .N(H - 2)) u_dly_s (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_d   (r_svm),
        .o_q   (w_svm)
    );

    gcd_delay #(.W(3), .N(gcd_pkg::COS_TERMS * H)) u_dly_ctl (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_d   (r_ctl5),
        .o_q   (w_ctl)
    );

    // map by quadrant
    assign w_sv = w_ctl[2] ? -$signed({1'b0, w_svm}) : $signed({1'b0, w_svm});
    assign w_cv = $signed({1'b0, w_ct[gcd_pkg::COS_TERMS]});

    always_comb begin
        case (gcd_pkg::t_quad'(w_ctl[1:0]))
            gcd_pkg::QUAD_0: begin
                n_sin = w_sv;
                n_cos = w_cv;
            end
            gcd_pkg::QUAD_1: begin
                n_sin = w_cv;
                n_cos = -w_sv;
            end
            gcd_pkg::QUAD_2: begin
                n_sin = -w_sv;
                n_cos = -w_cv;
            end
            default: begin
                n_sin = -w_cv;
                n_cos = w_sv;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= n_sin;
            r_cos <= n_cos;
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

### hw/rtl/gcd_acos_step.sv
// ----------------------------------------------------------------------------
// gcd_acos_step
// One bisection step of the inverse cosine: try the next bit of the angle
// and keep it where the cosine is still at least the argument.
// ----------------------------------------------------------------------------
module gcd_acos_step #(
    parameter int STEP = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [30:0]   i_lo,
    input  gcd_pkg::t_q30 i_arg,
    output logic [30:0]   o_lo,
    output gcd_pkg::t_q30 o_arg
);

    localparam logic [30:0] TRY_BIT = 31'(1) << (30 - STEP);

    logic [30:0]   w_mid;
    logic [30:0]   w_midd;
    gcd_pkg::t_q30 w_argd;
    gcd_pkg::t_q30 w_sin;
    gcd_pkg::t_q30 w_cos;
    logic [30:0]   r_lo;
    gcd_pkg::t_q30 r_arg;

    // midpoint of the current interval
    assign w_mid = i_lo | TRY_BIT;

    gcd_sincos u_sc (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_ang ({1'b0, w_mid}),
        .o_sin (w_sin),
        .o_cos (w_cos)
    );

    gcd_delay #(.W(63), .N(gcd_pkg::LAT_SC)) u_dly (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_d   ({w_mid, i_arg}),
        .o_q   ({w_midd, w_argd})
    );

    // keep or drop the trial bit
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo  <= (w_cos >= w_argd) ? w_midd : (w_midd & ~TRY_BIT);
            r_arg <= w_argd;
        end
    end

    assign o_lo  = r_lo;
    assign o_arg = r_arg;

endmodule

### hw/rtl/great_circle_distance.sv
// Throughput: one transaction per cycle unless the output stalls; every unit is fully
// pipelined and the 31 bisection steps of the inverse cosine each carry their own
// sine/cosine unit.
// A stall at the output freezes the whole pipeline; nothing is lost or repeated.
// Reset (synchronous, active low) empties the pipeline and sets the radius to 6371 km.
// ----------------------------------------------------------------------------
// great_circle_distance
// Central angle and surface distance between two points by the spherical
// law of cosines, with a writable sphere radius.
// ----------------------------------------------------------------------------
module great_circle_distance #(
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [13:0] i_cfg_data,
    gcd_pt_if.sink      i_pt,
    gcd_res_if.source   o_res
);

    localparam int L = gcd_pkg::LAT_TOTAL;
    localparam int S = gcd_pkg::ACOS_STEPS;

    logic                  w_en;
    logic [L-1:0]          r_valid;
    logic [13:0]           r_radius;
    logic signed [25:0]    r_lat1, r_lat2, r_dlon;
    logic [31:0]           w_t1, w_t2, w_td;
    gcd_pkg::t_q30         w_s1, w_c1, w_s2, w_c2, w_sd, w_cd;
    logic [30:0]           w_ms1, w_ms2, w_mc1, w_mc2;
    logic [61:0]           r_pss, r_pcc;
    logic                  r_nss, r_ncc;
    gcd_pkg::t_q30         r_cd1, r_cd2;
    logic [61:0]           w_rss, w_rcc;
    gcd_pkg::t_q30         r_mss2, r_mcc2;
    logic [30:0]           w_mmcc, w_mcd;
    logic [61:0]           r_pccd;
    logic                  r_nccd;
    gcd_pkg::t_q30         r_mss3;
    logic [61:0]           w_rccd;
    gcd_pkg::t_q30         r_mccd4, r_mss4;
    logic signed [32:0]    w_sum;
    gcd_pkg::t_q30         r_arg;
    logic [30:0]           w_lo  [S+1];
    gcd_pkg::t_q30         w_carg [S+1];
    logic [62:0]           r_aprod;
    logic [62:0]           w_asum;
    logic [31:0]           r_angle, r_ang1, r_ang2, r_out_ang;
    logic [45:0]           r_dp1;
    logic [56:0]           r_dp2;
    logic [56:0]           w_dsum;
    logic [25:0]           r_out_dist;

    // whole pipeline advances unless the output register is held
    assign w_en = !r_valid[L-1] || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_en) begin
            r_valid <= {r_valid[L-2:0], i_pt.valid};
        end
    end

    // radius register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= gcd_pkg::RADIUS_RESET;
        end else if (i_cfg_we) begin
            r_radius <= i_cfg_data;
        end
    end

    // capture the transaction and form the longitude difference
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lat1 <= 26'(i_pt.lat_first);
            r_lat2 <= 26'(i_pt.lat_second);
            r_dlon <= 26'(i_pt.lon_first) - 26'(i_pt.lon_second);
        end
    end

    // degrees to binary angles
    gcd_d2t #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_d2t_lat1 (
        .i_clk (i_clk), .i_en (w_en), .i_deg (r_lat1), .o_turn (w_t1)
    );
    gcd_d2t #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_d2t_lat2 (
        .i_clk (i_clk), .i_en (w_en), .i_deg (r_lat2), .o_turn (w_t2)
    );
    gcd_d2t #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_d2t_dlon (
        .i_clk (i_clk), .i_en (w_en), .i_deg (r_dlon), .o_turn (w_td)
    );

    // sines and cosines
    gcd_sincos u_sc_lat1 (
        .i_clk (i_clk), .i_en (w_en), .i_ang (w_t1), .o_sin (w_s1), .o_cos (w_c1)
    );
    gcd_sincos u_sc_lat2 (
        .i_clk (i_clk), .i_en (w_en), .i_ang (w_t2), .o_sin (w_s2), .o_cos (w_c2)
    );
    gcd_sincos u_sc_dlon (
        .i_clk (i_clk), .i_en (w_en), .i_ang (w_td), .o_sin (w_sd), .o_cos (w_cd)
    );

    // magnitudes for the rounded Q30 products
    assign w_ms1  = w_s1[31] ? 31'(-w_s1) : 31'(w_s1);
    assign w_ms2  = w_s2[31] ? 31'(-w_s2) : 31'(w_s2);
    assign w_mc1  = w_c1[31] ? 31'(-w_c1) : 31'(w_c1);
    assign w_mc2  = w_c2[31] ? 31'(-w_c2) : 31'(w_c2);
    assign w_rss  = r_pss + 62'(2**29);
    assign w_rcc  = r_pcc + 62'(2**29);
    assign w_mmcc = r_mcc2[31] ? 31'(-r_mcc2) : 31'(r_mcc2);
    assign w_mcd  = r_cd2[31] ? 31'(-r_cd2) : 31'(r_cd2);
    assign w_rccd = r_pccd + 62'(2**29);
    assign w_sum  = 33'(r_mss4) + 33'(r_mccd4);

    // cosine-law argument, clamped to [-1, 1]
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pss   <= 62'(w_ms1) * 62'(w_ms2);
            r_nss   <= w_s1[31] ^ w_s2[31];
            r_pcc   <= 62'(w_mc1) * 62'(w_mc2);
            r_ncc   <= w_c1[31] ^ w_c2[31];
            r_cd1   <= w_cd;

            r_mss2  <= r_nss ? -$signed({1'b0, w_rss[60:30]}) : $signed({1'b0, w_rss[60:30]});
            r_mcc2  <= r_ncc ? -$signed({1'b0, w_rcc[60:30]}) : $signed({1'b0, w_rcc[60:30]});
            r_cd2   <= r_cd1;

            r_pccd  <= 62'(w_mmcc) * 62'(w_mcd);
            r_nccd  <= r_mcc2[31] ^ r_cd2[31];
            r_mss3  <= r_mss2;

            r_mccd4 <= r_nccd ? -$signed({1'b0, w_rccd[60:30]})
                              : $signed({1'b0, w_rccd[60:30]});
            r_mss4  <= r_mss3;

            if (w_sum > 33'sh0_4000_0000) begin
                r_arg <= 32'sh4000_0000;
            end else if (w_sum < -33'sh0_4000_0000) begin
                r_arg <= -32'sh4000_0000;
            end else begin
                r_arg <= 32'(w_sum);
            end
        end
    end

    // inverse cosine by bisection
    assign w_lo[0]   = '0;
    assign w_carg[0] = r_arg;

    for (genvar i = 0; i < S; i++) begin : g_acos
        gcd_acos_step #(.STEP(i)) u_step (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_lo  (w_lo[i]),
            .i_arg (w_carg[i]),
            .o_lo  (w_lo[i+1]),
            .o_arg (w_carg[i+1])
        );
    end

    // angle in radians, then distance in metres
    assign w_asum = r_aprod + 63'(2**30);
    assign w_dsum = r_dp2 + 57'(2**29);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_aprod    <= 63'(w_lo[S]) * 63'(gcd_pkg::PI_Q30);
            r_angle    <= w_asum[62:31];
            r_dp1      <= 46'(r_angle) * 46'(r_radius);
            r_ang1     <= r_angle;
            r_dp2      <= 57'(r_dp1) * 57'(1000);
            r_ang2     <= r_ang1;
            r_out_dist <= w_dsum[55:30];
            r_out_ang  <= r_ang2;
        end
    end

    assign i_pt.ready          = w_en;
    assign o_res.valid         = r_valid[L-1];
    assign o_res.central_angle = r_out_ang;
    assign o_res.distance_m    = r_out_dist;

endmodule

### tb/great_circle_distance_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// great_circle_distance_tb
// Drives coordinate pairs into the great-circle distance datapath, predicts
// central angle and distance for each accepted transaction from a local
// fixed-point model, and checks every result in order, with random sender
// gaps, receiver stalls and several sphere radii.
// ----------------------------------------------------------------------------
module great_circle_distance_tb;

    localparam longint ONE      = 64'sd1 << 30;
    localparam longint PI_FIX   = 64'sd3373259426;
    localparam longint DEG90    = 64'sd5898240;
    localparam longint DEG180   = 64'sd11796480;
    localparam int     LIMIT    = 600000;
    localparam int     RAND_NUM = 600;
    localparam int     HOLD_LEN = 2000;
    localparam int     BP_NUM   = 250;

    typedef struct {
        logic signed [23:0] lat1;
        logic signed [24:0] lon1;
        logic signed [23:0] lat2;
        logic signed [24:0] lon2;
    } t_point_pair;

    typedef struct {
        logic [31:0] angle;
        logic [25:0] dist_m;
    } t_distance;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [13:0] i_cfg_data;

    gcd_pt_if  pt();
    gcd_res_if res();

    great_circle_distance u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_pt       (pt.sink),
        .o_res      (res.source)
    );

    t_distance   expected_dist[$];
    logic [13:0] radius_km;
    int          mismatches = 0;
    int          cycles = 0;
    int          burst_left;
    bit          hold_req = 1'b0;
    bit          hold_armed = 1'b0;
    int          hold_left = 0;
    bit          no_gaps;

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------ model
    function automatic longint q30_mul(longint a, longint b);
        longint ma, mb, p;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        p  = (ma * mb + (64'sd1 << 29)) >>> 30;
        return ((a < 0) != (b < 0)) ? -p : p;
    endfunction

    function automatic logic [31:0] turn_of_deg(longint d);
        longint m, q;
        logic [31:0] t;
        m = (d < 0) ? -d : d;
        q = ((m <<< 16) + 180) / 360;
        t = q[31:0];
        return (d < 0) ? (32'd0 - t) : t;
    endfunction

    function automatic void sin_cos_q30(input logic [31:0] a,
                                        output longint s_out, output longint c_out);
        int sdiv[5] = '{110, 72, 42, 20, 6};
        int cdiv[6] = '{132, 90, 56, 30, 12, 2};
        logic [31:0] b;
        longint r, mr, x, x2, ts, tc, sv, cv;
        b  = a + 32'h2000_0000;
        r  = longint'(b[29:0]) - (64'sd1 << 29);
        mr = (r < 0) ? -r : r;
        x  = (mr * PI_FIX + (64'sd1 << 30)) >>> 31;
        if (r < 0) x = -x;
        x2 = q30_mul(x, x);
        ts = ONE;
        foreach (sdiv[i]) ts = ONE - q30_mul(x2, ts) / sdiv[i];
        sv = q30_mul(x, ts);
        tc = ONE;
        foreach (cdiv[i]) tc = ONE - q30_mul(x2, tc) / cdiv[i];
        cv = tc;
        // map the result back into its quadrant
        case (gcd_pkg::t_quad'(b[31:30]))
            gcd_pkg::QUAD_0: begin s_out = sv;  c_out = cv;  end
            gcd_pkg::QUAD_1: begin s_out = cv;  c_out = -sv; end
            gcd_pkg::QUAD_2: begin s_out = -sv; c_out = -cv; end
            default: begin s_out = -cv; c_out = sv; end
        endcase
    endfunction

    function automatic longint acos_q30(longint c);
        longint lo, hi, mid, sv, cv;
        lo = 0;
        hi = 64'sd1 << 31;
        for (int i = 0; i < 31; i++) begin
            mid = (lo + hi) >>> 1;
            sin_cos_q30(mid[31:0], sv, cv);
            if (cv >= c) lo = mid;
            else hi = mid;
        end
        return (lo * PI_FIX + (64'sd1 << 30)) >>> 31;
    endfunction

    function automatic t_distance predict_distance(t_point_pair p, logic [13:0] rad);
        longint s1, c1, s2, c2, sd, cd, arg, ang, dist_q;
        t_distance d;
        sin_cos_q30(turn_of_deg(longint'(p.lat1)), s1, c1);
        sin_cos_q30(turn_of_deg(longint'(p.lat2)), s2, c2);
        sin_cos_q30(turn_of_deg(longint'(p.lon1) - longint'(p.lon2)), sd, cd);
        arg = q30_mul(s1, s2) + q30_mul(q30_mul(c1, c2), cd);
        // clamp the argument to the domain of acos
        if (arg > ONE) arg = ONE;
        if (arg < -ONE) arg = -ONE;
        ang    = acos_q30(arg);
        dist_q = (ang * longint'(rad) * 1000 + (64'sd1 << 29)) >>> 30;
        d.angle  = ang[31:0];
        d.dist_m = dist_q[25:0];
        return d;
    endfunction

    // --------------------------------------------------------------- monitors
    // Predict each accepted coordinate transaction
    always @(posedge i_clk) begin
        t_point_pair p;
        if (i_rst_n && pt.valid && pt.ready) begin
            p.lat1 = pt.lat_first;
            p.lon1 = pt.lon_first;
            p.lat2 = pt.lat_second;
            p.lon2 = pt.lon_second;
            expected_dist.push_back(predict_distance(p, radius_km));
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_distance e;
        if (i_rst_n && res.valid && res.ready) begin
            if (expected_dist.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: angle %0d dist %0d",
                             res.central_angle, res.distance_m);
            end else begin
                e = expected_dist.pop_front();
                if (e.angle !== res.central_angle || e.dist_m !== res.distance_m) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: angle exp %0d got %0d, dist exp %0d got %0d",
                                 e.angle, res.central_angle, e.dist_m, res.distance_m);
                end
            end
        end
    end

    // Stall the receiver on its own pattern; hold off for a long stretch on request
    always @(posedge i_clk) begin
        int mode;
        if (hold_req && !hold_armed) begin
            hold_armed <= 1'b1;
            hold_left  <= HOLD_LEN - 1;
            res.ready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            res.ready <= 1'b0;
        end else begin
            if (!hold_req) hold_armed <= 1'b0;
            mode = (cycles / 97) % 4;
            case (mode)
                0: res.ready <= 1'b1;
                1: res.ready <= ($urandom_range(0, 1) == 1);
                2: res.ready <= ((cycles % 8) < 5);
                default: res.ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------ tasks
    task automatic send_pair(t_point_pair p);
        int gap;
        pt.valid      <= 1'b1;
        pt.lat_first  <= p.lat1;
        pt.lon_first  <= p.lon1;
        pt.lat_second <= p.lat2;
        pt.lon_second <= p.lon2;
        @(posedge i_clk);
        while (!pt.ready) @(posedge i_clk);
        // end the burst with a random gap
        if (!no_gaps) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(0, 24);
                gap = $urandom_range(0, 7);
                if (gap > 0) begin
                    pt.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic drop_valid();
        pt.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (expected_dist.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_radius(logic [13:0] r);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= r;
        radius_km   = r;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_point_pair pair_of(longint a, longint b, longint c, longint d);
        t_point_pair p;
        p.lat1 = a[23:0];
        p.lon1 = b[24:0];
        p.lat2 = c[23:0];
        p.lon2 = d[24:0];
        return p;
    endfunction

    function automatic t_point_pair random_pair();
        t_point_pair p;
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
            // well-formed coordinates
            p.lat1 = 24'(longint'($urandom_range(0, 2 * DEG90)) - DEG90);
            p.lon1 = 25'(longint'($urandom_range(0, 2 * DEG180)) - DEG180);
            p.lat2 = 24'(longint'($urandom_range(0, 2 * DEG90)) - DEG90);
            p.lon2 = 25'(longint'($urandom_range(0, 2 * DEG180)) - DEG180);
        end else if (kind < 8) begin
            // second point close to the first
            p.lat1 = 24'(longint'($urandom_range(0, 2 * DEG90)) - DEG90);
            p.lon1 = 25'(longint'($urandom_range(0, 2 * DEG180)) - DEG180);
            p.lat2 = p.lat1 + 24'($signed($urandom_range(0, 64)) - 32);
            p.lon2 = p.lon1 + 25'($signed($urandom_range(0, 64)) - 32);
        end else begin
            // any bit pattern, wrapping angles
            p.lat1 = 24'($urandom);
            p.lon1 = 25'($urandom);
            p.lat2 = 24'($urandom);
            p.lon2 = 25'($urandom);
        end
        return p;
    endfunction

    // -------------------------------------------------------------- the tests
    task automatic test_directed();
        send_pair(pair_of(0, 0, 0, 0));
        send_pair(pair_of(DEG90, 0, -DEG90, 0));
        send_pair(pair_of(0, 0, 0, DEG180));
        send_pair(pair_of(0, -DEG180, 0, DEG180));
        send_pair(pair_of(DEG90, DEG180, DEG90, -DEG180));
        send_pair(pair_of(-DEG90, 123456, -DEG90, -654321));
        send_pair(pair_of(0, DEG180 / 2, 0, -DEG180 / 2));
        send_pair(pair_of(DEG90 / 2, DEG180 / 3, -DEG90 / 2, -2 * DEG180 / 3));
        send_pair(pair_of(1000000, 2000000, 1000001, 2000001));
        send_pair(pair_of(-3000000, 5000000, -3000000, 5000000));
        send_pair(pair_of(1, 0, 0, 0));
        send_pair(pair_of(-(64'sd1 << 23), -(64'sd1 << 24), (64'sd1 << 23) - 1,
                          (64'sd1 << 24) - 1));
        send_pair(pair_of((64'sd1 << 23) - 1, (64'sd1 << 24) - 1, -(64'sd1 << 23),
                          -(64'sd1 << 24)));
        send_pair(pair_of(-1, -1, -1, -1));
        send_pair(pair_of(DEG90 + 65536, 0, DEG90 - 65536, 0));
        send_pair(pair_of(0, 3 * DEG180 / 2, 0, -3 * DEG180 / 2));
        drop_valid();
    endtask

    task automatic test_radius_settings();
        logic [13:0] radii[4] = '{14'd0, 14'd1, 14'd16383, 14'd0};
        radii[3] = 14'($urandom_range(2, 16382));
        foreach (radii[i]) begin
            write_radius(radii[i]);
            send_pair(pair_of(0, 0, 0, DEG180));
            send_pair(pair_of(DEG90, 0, -DEG90, 0));
            for (int k = 0; k < 8; k++) send_pair(random_pair());
            drop_valid();
        end
    endtask

    task automatic test_random_traffic();
        for (int i = 0; i < RAND_NUM; i++) begin
            send_pair(random_pair());
            // pause until every result has come, then change the radius
            if (i % 150 == 149) begin
                drop_valid();
                write_radius(14'($urandom_range(0, 16383)));
            end
        end
        drop_valid();
    endtask

    task automatic test_output_backpressure();
        wait_drained();
        no_gaps  = 1'b1;
        hold_req = 1'b1;
        // keep offering sparse transactions while the receiver holds off
        for (int i = 0; i < BP_NUM; i++) begin
            send_pair(random_pair());
            drop_valid();
            repeat (6) @(posedge i_clk);
        end
        hold_req = 1'b0;
        no_gaps  = 1'b0;
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_data    <= '0;
        pt.valid      <= 1'b0;
        pt.lat_first  <= '0;
        pt.lon_first  <= '0;
        pt.lat_second <= '0;
        pt.lon_second <= '0;
        radius_km   = 14'd6371;
        burst_left  = 0;
        no_gaps     = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_radius_settings();
        test_random_traffic();
        test_output_backpressure();

        wait_drained();
        repeat (gcd_pkg::LAT_TOTAL + 20) @(posedge i_clk);
        if (mismatches == 0 && expected_dist.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

### filelist.f
hw/rtl/gcd_pkg.sv
hw/rtl/gcd_if.sv
hw/rtl/gcd_delay.sv
hw/rtl/gcd_divc.sv
hw/rtl/gcd_d2t.sv
hw/rtl/gcd_horner.sv
hw/rtl/gcd_sincos.sv
hw/rtl/gcd_acos_step.sv
hw/rtl/great_circle_distance.sv
tb/great_circle_distance_tb.sv
